[hdl/olisd_pkg.sv]
// Shared types and codes for the ordered list block.
// Holds the request and result item structs and the per-cell control struct.
package olisd_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_DUMP   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] item_value;
	} olisd_req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               found;
		logic [1:0]         status;
		logic               last;
	} olisd_rsp_t;

	typedef struct packed {
		logic wr;
		logic rot;
		logic del;
	} olisd_cell_ctl_t;

endpackage

[hdl/olisd_cell.sv]
// One cell of the list chain: one entry, its match logic and search token stage.
// Depends on olisd_pkg for the cell control struct.
module olisd_cell import olisd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  olisd_cell_ctl_t    ctl,
	input  logic signed [31:0] wr_value,
	input  logic signed [31:0] nb_value,
	input  logic signed [31:0] key,
	input  logic               in_list,
	input  logic               tok_in,
	input  logic               hit_in,
	output logic signed [31:0] value,
	output logic               tok,
	output logic               hit
);

	logic signed [31:0] value_q;
	logic               tok_q;
	logic               hit_q;
	logic               mark_q;
	logic               match;

	assign match = in_list && (value_q == key);

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			value_q <= wr_value;
		end else if (ctl.rot || (ctl.del && mark_q)) begin
			value_q <= nb_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			hit_q  <= 1'b0;
			mark_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (tok_in) begin
				hit_q  <= hit_in | match;
				mark_q <= hit_in | match;
			end
		end
	end

	assign value = value_q;
	assign tok   = tok_q;
	assign hit   = hit_q;

endmodule

[hdl/ordered_list_insert_search_delete.sv]
// Top level of the ordered list: request control, result register and the cell chain.
// Depends on olisd_pkg and olisd_cell.

// The list lives in a chain of DEPTH cells, head in cell 0. Insert writes the
// cell at the tail. Search and delete send a token down the chain, one cell
// per cycle; a delete then moves every entry behind the match one cell toward
// the head at once. Dump rotates the whole chain through cell 0 once, pausing
// while the result side stalls. One request is worked at a time.
module ordered_list_insert_search_delete import olisd_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  olisd_req_t req_data,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output olisd_rsp_t rsp_data
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_DUMP
	} st_t;

	st_t                st_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      k_q;
	logic signed [31:0] key_q;
	logic [1:0]         req_q;
	logic               found_q;
	logic               ovld_q;
	olisd_rsp_t         out_q;

	logic signed [31:0] cval [DEPTH];
	logic [DEPTH-1:0]   tok;
	logic [DEPTH-1:0]   hit;
	olisd_cell_ctl_t    ctl [DEPTH];

	logic ofree;
	logic accept;
	logic start;
	logic rot;
	logic emit_dump;
	logic del_go;
	logic ins_go;
	logic full;

	assign ofree     = !ovld_q || !rsp_stall;
	assign req_stall = (st_q != ST_IDLE) || !ofree;
	assign accept    = req_valid && !req_stall;
	assign full      = (cnt_q == CW'(DEPTH));
	assign start     = accept && (req_data.req_type == REQ_SEARCH ||
		req_data.req_type == REQ_DELETE) && (cnt_q != '0);
	assign ins_go    = accept && (req_data.req_type == REQ_INSERT) && !full;
	assign emit_dump = (st_q == ST_DUMP) && (k_q < cnt_q) && ofree;
	assign rot       = (st_q == ST_DUMP) && ((k_q >= cnt_q) || ofree);
	assign del_go    = (st_q == ST_FIN) && ofree && (req_q == REQ_DELETE) && found_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic tin;
		logic hin;

		if (i == 0) begin : g_head
			assign tin = start;
			assign hin = 1'b0;
		end else begin : g_body
			assign tin = tok[i-1];
			assign hin = hit[i-1];
		end

		assign ctl[i].wr  = ins_go && (cnt_q == CW'(i));
		assign ctl[i].rot = rot;
		assign ctl[i].del = del_go;

		olisd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.wr_value (req_data.item_value),
			.nb_value (cval[(i + 1) % DEPTH]),
			.key      (start ? req_data.item_value : key_q),
			.in_list  (CW'(i) < cnt_q),
			.tok_in   (tin),
			.hit_in   (hin),
			.value    (cval[i]),
			.tok      (tok[i]),
			.hit      (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			key_q   <= '0;
			req_q   <= REQ_INSERT;
			found_q <= 1'b0;
			ovld_q  <= 1'b0;
			out_q   <= '0;
		end else begin
			if (ovld_q && !rsp_stall) begin
				ovld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						key_q <= req_data.item_value;
						req_q <= req_data.req_type;
						case (req_data.req_type)
							REQ_INSERT: begin
								ovld_q          <= 1'b1;
								out_q.out_value <= req_data.item_value;
								out_q.found     <= 1'b0;
								out_q.status    <= full ? STAT_FULL : STAT_OK;
								out_q.last      <= 1'b1;
								if (!full) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							REQ_SEARCH, REQ_DELETE: begin
								if (cnt_q == '0) begin
									ovld_q          <= 1'b1;
									out_q.out_value <= req_data.item_value;
									out_q.found     <= 1'b0;
									out_q.status    <= STAT_EMPTY;
									out_q.last      <= 1'b1;
								end else begin
									st_q <= ST_SCAN;
								end
							end
							default: begin
								if (cnt_q == '0) begin
									ovld_q          <= 1'b1;
									out_q.out_value <= '0;
									out_q.found     <= 1'b0;
									out_q.status    <= STAT_EMPTY;
									out_q.last      <= 1'b1;
								end else begin
									k_q  <= '0;
									st_q <= ST_DUMP;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (tok[DEPTH-1]) begin
						found_q <= hit[DEPTH-1];
						st_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (ofree) begin
						ovld_q          <= 1'b1;
						out_q.out_value <= key_q;
						out_q.found     <= found_q;
						out_q.status    <= STAT_OK;
						out_q.last      <= 1'b1;
						if (del_go) begin
							cnt_q <= cnt_q - CW'(1);
						end
						st_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (emit_dump) begin
						ovld_q          <= 1'b1;
						out_q.out_value <= cval[0];
						out_q.found     <= 1'b0;
						out_q.status    <= STAT_OK;
						out_q.last      <= (k_q == cnt_q - CW'(1));
					end
					if (rot) begin
						k_q <= k_q + CW'(1);
						if (k_q == CW'(DEPTH - 1)) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = ovld_q;
	assign rsp_data  = out_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one search token in the chain");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		del_go |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("delete did not shorten the list");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(tok != '0) |-> st_q == ST_SCAN)
		else $error("search token outside a scan");
`endif

endmodule
